FILE: design/inversion_table_to_tree_edges_assert.svh
// Assertion macros for the tree edge builder.
`ifndef INVERSION_TABLE_TO_TREE_EDGES_ASSERT_SVH
`define INVERSION_TABLE_TO_TREE_EDGES_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define ITTE_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define ITTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/itte_pkg.sv
// Shared constants and types for the tree edge builder.
package itte_pkg;

    localparam int LEVEL_W       = 10;
    localparam int NODE_W        = 10;
    localparam int STACK_DEPTH   = 1024;
    localparam int ADDR_W        = $clog2(STACK_DEPTH);
    localparam int COUNT_W       = ADDR_W + 1;
    localparam int MAX_NODES_DEF = 1024;
    localparam int STATUS_W      = 2;

    localparam int S_TDATA_W = ((LEVEL_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W + 2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ANC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [NODE_W-1:0]  node;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/itte_ram.sv
// Generic simple dual-port RAM with registered read.
module itte_ram #(
    parameter int WIDTH = itte_pkg::ENTRY_W,
    parameter int DEPTH = itte_pkg::STACK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/inversion_table_to_tree_edges.sv
// Top level of the preorder inversion table to tree edge builder.
// Each request carries one inversion table entry and yields one result: the
// new node's preorder index, its parent and its side, or an error status when
// no path entry has a level at most the input or the table is full. The path
// from the root lives in a 1024-entry RAM with a registered copy of the top
// entry. A request that starts a table, pushes a left child or hangs a right
// child on the top entry goes straight to the result; a pop walks the path,
// one RAM read per popped entry. The RAM needs no clearing after reset.
module inversion_table_to_tree_edges #(
    parameter int MAX_NODES = itte_pkg::MAX_NODES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [itte_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] level
    input  logic [itte_pkg::S_TUSER_W-1:0] s_tuser,   // [0] start_req
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [itte_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] node_id, [19:10] parent_id
    output logic [itte_pkg::M_TUSER_W-1:0] m_tuser    // [0] side, [1] is_root, [3:2] status
);

`include "inversion_table_to_tree_edges_assert.svh"

    localparam int ADDR_W  = itte_pkg::ADDR_W;
    localparam int COUNT_W = itte_pkg::COUNT_W;
    localparam int LEVEL_W = itte_pkg::LEVEL_W;
    localparam int NODE_W  = itte_pkg::NODE_W;
    localparam int PAD_W   = itte_pkg::M_TDATA_W - 2 * NODE_W;
    localparam int CAP_INT = (MAX_NODES > itte_pkg::STACK_DEPTH) ?
                             itte_pkg::STACK_DEPTH : MAX_NODES;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [COUNT_W-1:0]              path_top_reg, path_top_next;
    logic [COUNT_W-1:0]              node_count_reg, node_count_next;
    logic [LEVEL_W-1:0]              top_level_reg, top_level_next;
    logic [NODE_W-1:0]               top_node_reg, top_node_next;
    logic [LEVEL_W-1:0]              lvl_reg, lvl_next;
    logic [ADDR_W-1:0]               walk_reg, walk_next;
    logic [NODE_W-1:0]               res_node_reg, res_node_next;
    logic [NODE_W-1:0]               res_parent_reg, res_parent_next;
    logic                            res_side_reg, res_side_next;
    logic                            res_root_reg, res_root_next;
    logic [itte_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [itte_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [itte_pkg::M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    itte_pkg::entry_t                ram_wdata;
    logic [ADDR_W-1:0]               ram_raddr;
    itte_pkg::entry_t                ram_rdata;

    logic [LEVEL_W-1:0]              lvl_in;
    logic                            start_in;

    assign lvl_in   = s_tdata[LEVEL_W-1:0];
    assign start_in = s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    itte_ram #(
        .WIDTH(itte_pkg::ENTRY_W),
        .DEPTH(itte_pkg::STACK_DEPTH)
    ) u_path_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        path_top_next   = path_top_reg;
        node_count_next = node_count_reg;
        top_level_next  = top_level_reg;
        top_node_next   = top_node_reg;
        lvl_next        = lvl_reg;
        walk_next       = walk_reg;
        res_node_next   = res_node_reg;
        res_parent_next = res_parent_reg;
        res_side_next   = res_side_reg;
        res_root_next   = res_root_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = path_top_reg[ADDR_W-1:0];
        ram_wdata       = '{level: lvl_in, node: node_count_reg[NODE_W-1:0]};
        ram_raddr       = walk_reg - ADDR_W'(1);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_node_next   = node_count_reg[NODE_W-1:0];
                    res_parent_next = '0;
                    res_side_next   = 1'b0;
                    res_root_next   = 1'b0;
                    res_status_next = itte_pkg::STATUS_OK;
                    state_next      = ST_EMIT;
                    if (start_in || node_count_reg == '0 || path_top_reg == '0) begin
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        ram_wdata       = '{level: lvl_in, node: '0};
                        path_top_next   = COUNT_W'(1);
                        node_count_next = COUNT_W'(1);
                        top_level_next  = lvl_in;
                        top_node_next   = '0;
                        res_node_next   = '0;
                        res_root_next   = 1'b1;
                    end else if (node_count_reg >= CAP) begin
                        res_status_next = itte_pkg::STATUS_FULL;
                    end else if (lvl_in >= top_level_reg) begin
                        ram_we          = 1'b1;
                        path_top_next   = path_top_reg + COUNT_W'(1);
                        node_count_next = node_count_reg + COUNT_W'(1);
                        top_level_next  = lvl_in;
                        top_node_next   = node_count_reg[NODE_W-1:0];
                        res_parent_next = top_node_reg;
                        res_side_next   = (lvl_in == top_level_reg);
                    end else if (path_top_reg == COUNT_W'(1)) begin
                        res_status_next = itte_pkg::STATUS_NO_ANC;
                    end else begin
                        // pop the cached top, fetch the entry below it
                        ram_raddr  = path_top_reg[ADDR_W-1:0] - ADDR_W'(2);
                        walk_next  = path_top_reg[ADDR_W-1:0] - ADDR_W'(1);
                        lvl_next   = lvl_in;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (ram_rdata.level > lvl_reg) begin
                    if (walk_reg == ADDR_W'(1)) begin
                        res_status_next = itte_pkg::STATUS_NO_ANC;
                        state_next      = ST_EMIT;
                    end else begin
                        ram_raddr = walk_reg - ADDR_W'(2);
                        walk_next = walk_reg - ADDR_W'(1);
                    end
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = walk_reg;
                    ram_wdata       = '{level: lvl_reg, node: node_count_reg[NODE_W-1:0]};
                    path_top_next   = {1'b0, walk_reg} + COUNT_W'(1);
                    node_count_next = node_count_reg + COUNT_W'(1);
                    top_level_next  = lvl_reg;
                    top_node_next   = node_count_reg[NODE_W-1:0];
                    res_parent_next = ram_rdata.node;
                    res_side_next   = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_parent_reg, res_node_reg};
                    m_tuser_next  = {res_status_reg, res_root_reg, res_side_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            path_top_reg   <= '0;
            node_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            path_top_reg   <= path_top_next;
            node_count_reg <= node_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_level_reg  <= top_level_next;
        top_node_reg   <= top_node_next;
        lvl_reg        <= lvl_next;
        walk_reg       <= walk_next;
        res_node_reg   <= res_node_next;
        res_parent_reg <= res_parent_next;
        res_side_reg   <= res_side_next;
        res_root_reg   <= res_root_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    `ITTE_ASSERT_HOLDS(a_top_within_count, path_top_reg <= node_count_reg, "path deeper than node count")
    `ITTE_ASSERT_HOLDS(a_walk_below_top, (state_reg != ST_WALK) || ({1'b0, walk_reg} < path_top_reg), "walk index not below path top")
    `ITTE_ASSERT_NEXT(a_write_then_emit, ram_we, state_reg == ST_EMIT, "path write without a result")
    `ITTE_ASSERT_HOLDS(a_emit_path_open, (state_reg != ST_EMIT) || (path_top_reg != '0), "result with empty path")

endmodule
